// ===== hw/rtl/mppt_po_pkg.sv =====
// ----------------------------------------------------------------------------
// mppt_po_pkg
// Shared types, codes and constants of the perturb-and-observe charge controller.
// ----------------------------------------------------------------------------
package mppt_po_pkg;

  localparam int ADC_BITS_DEF = 10;
  localparam int Q_DEPTH_DEF  = 4;

  localparam int RAW_W   = 10;
  localparam int MV_W    = 16;
  localparam int MA_W    = 11;
  localparam int DUTY_W  = 8;
  localparam int SCALE_W = 15;
  localparam int CHG_W   = 12;
  localparam int FUNC_W  = 3;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 80;

  // result layout on out_tdata
  localparam int OUT_DUTY_LSB    = 0;
  localparam int OUT_PWM_BIT     = 8;
  localparam int OUT_MODE_LSB    = 9;
  localparam int OUT_PV_MV_LSB   = 11;
  localparam int OUT_PV_MA_LSB   = 27;
  localparam int OUT_BAT_MV_LSB  = 38;
  localparam int OUT_BAT_IN_LSB  = 54;
  localparam int OUT_BAT_OUT_LSB = 65;
  localparam int OUT_PV_OK_BIT   = 76;
  localparam int OUT_BAT_OK_BIT  = 77;
  localparam int OUT_USED_W      = 78;

  localparam logic [FUNC_W-1:0] FUNC_SAMPLE    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DUTY_UP   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DUTY_DOWN = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_PWM_OFF   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_PWM_ON    = 3'd4;

  localparam logic [MODE_W-1:0] MODE_SHDN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INC  = 2'd2;

  localparam logic [DUTY_W-1:0] DUTY_RESET = 8'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PV_START   = 3'd0,
    REG_BAT_FULL   = 3'd1,
    REG_MIN_CHARGE = 3'd2,
    REG_DUTY_TOP   = 3'd3,
    REG_DUTY_BOT   = 3'd4,
    REG_SENSE_OK   = 3'd5,
    REG_PV_SCALE   = 3'd6,
    REG_BAT_SCALE  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [MV_W-1:0]    pv_start_mv;
    logic [MV_W-1:0]    bat_full_mv;
    logic [CHG_W-1:0]   min_charge_ma;
    logic [DUTY_W-1:0]  duty_top;
    logic [DUTY_W-1:0]  duty_bottom;
    logic [MV_W-1:0]    sense_valid_mv;
    logic [SCALE_W-1:0] pv_scale;
    logic [SCALE_W-1:0] bat_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pv_start_mv:    16'd13000,
    bat_full_mv:    16'd12500,
    min_charge_ma:  12'd40,
    duty_top:       8'd120,
    duty_bottom:    8'd40,
    sense_valid_mv: 16'd2500,
    pv_scale:       15'd21790,
    bat_scale:      15'd21904
  };

  // classified item handed from the front end to the tracker
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [MV_W-1:0]   pv_mv;
    logic [MA_W-1:0]   pv_ma;
    logic [MV_W-1:0]   bat_mv;
    logic [MA_W-1:0]   bat_in_ma;
    logic [MA_W-1:0]   bat_out_ma;
    logic              pv_ok;
    logic              bat_ok;
    logic              stop;
    logic              start;
  } item_t;

endpackage

// ===== hw/rtl/mppt_po_front.sv =====
// ----------------------------------------------------------------------------
// mppt_po_front
// Accepts input items, scales the ADC readings and classifies each sample.
// ----------------------------------------------------------------------------
module mppt_po_front
  import mppt_po_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [FUNC_W-1:0]     in_tuser,
  input  cfg_t                  cfg,
  output logic                  q_push,
  input  logic                  q_ready,
  output item_t                 q_item
);

  localparam int RW     = (ADC_BITS < RAW_W) ? ADC_BITS : RAW_W;
  localparam int PROD_W = RW + SCALE_W;
  // divide by 1000 as (p >> 3) / 125, the latter by an exact reciprocal
  localparam int DIV_N  = PROD_W - 3;
  localparam int DIV_S  = DIV_N + 7;
  localparam int RCP_W  = DIV_N + 1;
  localparam int QW     = DIV_N + RCP_W;
  localparam logic [63:0] RCP64 = ((64'd1 << DIV_S) + 64'd124) / 64'd125;
  localparam logic [RCP_W-1:0] RCP = RCP64[RCP_W-1:0];

  logic [RW-1:0] raw_pv_v, raw_pv_i, raw_bat_v, raw_bat_in, raw_bat_out;

  logic              v1_r;
  logic [FUNC_W-1:0] func1_r;
  logic [PROD_W-1:0] pv_prod1_r, bat_prod1_r;
  logic [MA_W-1:0]   pv_ma1_r, bat_in1_r, bat_out1_r;

  logic              v2_r;
  logic [FUNC_W-1:0] func2_r;
  logic [QW-1:0]     pv_q2_r, bat_q2_r;
  logic [MA_W-1:0]   pv_ma2_r, bat_in2_r, bat_out2_r;

  logic en1, en2;
  logic [MV_W-1:0] pv_mv, bat_mv;

  assign raw_pv_v    = in_tdata[0*RAW_W +: RW];
  assign raw_pv_i    = in_tdata[1*RAW_W +: RW];
  assign raw_bat_v   = in_tdata[2*RAW_W +: RW];
  assign raw_bat_in  = in_tdata[3*RAW_W +: RW];
  assign raw_bat_out = in_tdata[4*RAW_W +: RW];

  assign en2       = !v2_r || q_ready;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign q_push    = v2_r;

  function automatic logic [MV_W-1:0] sat_mv(input logic [QW-DIV_S-1:0] q);
    logic [31:0] qx;
    qx = 32'(q);
    return (qx > 32'd65535) ? 16'hFFFF : qx[MV_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      func1_r     <= in_tuser;
      pv_prod1_r  <= PROD_W'(raw_pv_v) * PROD_W'(cfg.pv_scale);
      bat_prod1_r <= PROD_W'(raw_bat_v) * PROD_W'(cfg.bat_scale);
      pv_ma1_r    <= MA_W'({raw_pv_i, 1'b0});
      bat_in1_r   <= MA_W'({raw_bat_in, 1'b0});
      bat_out1_r  <= MA_W'({raw_bat_out, 1'b0});
    end
    if (en2) begin
      func2_r    <= func1_r;
      pv_q2_r    <= QW'(pv_prod1_r[PROD_W-1:3]) * QW'(RCP);
      bat_q2_r   <= QW'(bat_prod1_r[PROD_W-1:3]) * QW'(RCP);
      pv_ma2_r   <= pv_ma1_r;
      bat_in2_r  <= bat_in1_r;
      bat_out2_r <= bat_out1_r;
    end
  end

  assign pv_mv  = sat_mv(pv_q2_r[QW-1:DIV_S]);
  assign bat_mv = sat_mv(bat_q2_r[QW-1:DIV_S]);

  always_comb begin
    q_item      = '0;
    q_item.func = func2_r;
    if (func2_r == FUNC_SAMPLE) begin
      q_item.pv_mv      = pv_mv;
      q_item.pv_ma      = pv_ma2_r;
      q_item.bat_mv     = bat_mv;
      q_item.bat_in_ma  = bat_in2_r;
      q_item.bat_out_ma = bat_out2_r;
      q_item.pv_ok      = pv_mv > cfg.sense_valid_mv;
      q_item.bat_ok     = bat_mv > cfg.sense_valid_mv;
      q_item.stop       = ({1'b0, bat_in2_r} < cfg.min_charge_ma)
                          || (bat_mv >= cfg.bat_full_mv);
      q_item.start      = (pv_mv > cfg.pv_start_mv) && (bat_mv < cfg.bat_full_mv);
    end
  end

endmodule

// ===== hw/rtl/mppt_po_fifo.sv =====
// ----------------------------------------------------------------------------
// mppt_po_fifo
// Short queue of classified items between the front end and the tracker.
// ----------------------------------------------------------------------------
module mppt_po_fifo
  import mppt_po_pkg::*;
#(
  parameter int DEPTH = Q_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign push_ready = cnt_r != CNT_W'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

// ===== hw/rtl/mppt_po_back.sv =====
// ----------------------------------------------------------------------------
// mppt_po_back
// Tracker: holds mode, duty and PWM state, applies each item, registers result.
// ----------------------------------------------------------------------------
module mppt_po_back
  import mppt_po_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  item_t                  q_item,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  typedef enum logic [2:0] {
    ST_SHDN = 3'b001,
    ST_DEC  = 3'b010,
    ST_INC  = 3'b100
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [DUTY_W-1:0]      duty_r, duty_nxt;
  logic                   pwm_r, pwm_nxt;
  logic [MV_W-1:0]        prev_r, prev_nxt;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   pop, ge;
  logic [DUTY_W:0]        dec9, inc9;
  logic [MODE_W-1:0]      mode_code;

  function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W:0] d,
                                                   input logic [DUTY_W-1:0] lo,
                                                   input logic [DUTY_W-1:0] hi);
    logic [DUTY_W:0] t;
    t = d;
    if (t < {1'b0, lo}) t = {1'b0, lo};
    if (t > {1'b0, hi}) t = {1'b0, hi};
    return t[DUTY_W-1:0];
  endfunction

  assign q_ready    = !out_valid_r || out_tready;
  assign pop        = q_valid && q_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign ge   = q_item.bat_mv >= prev_r;
  assign dec9 = {1'b0, duty_r} - 9'd1;
  assign inc9 = {1'b0, duty_r} + 9'd1;

  always_comb begin
    mode_nxt = mode_r;
    duty_nxt = duty_r;
    pwm_nxt  = pwm_r;
    prev_nxt = prev_r;
    unique case (q_item.func)
      FUNC_SAMPLE: begin
        prev_nxt = q_item.bat_mv;
        unique case (mode_r)
          ST_SHDN: begin
            if (q_item.start) begin
              duty_nxt = cfg.duty_top;
              pwm_nxt  = 1'b1;
              mode_nxt = ST_DEC;
            end
          end
          ST_DEC: begin
            if (q_item.stop) begin
              mode_nxt = ST_SHDN;
              pwm_nxt  = 1'b0;
            end else if (ge && duty_r > cfg.duty_bottom) begin
              duty_nxt = clamp_duty(dec9, cfg.duty_bottom, cfg.duty_top);
            end else begin
              duty_nxt = clamp_duty(inc9, cfg.duty_bottom, cfg.duty_top);
              mode_nxt = ST_INC;
            end
          end
          ST_INC: begin
            if (q_item.stop) begin
              mode_nxt = ST_SHDN;
              pwm_nxt  = 1'b0;
            end else if (ge && duty_r < cfg.duty_top) begin
              duty_nxt = clamp_duty(inc9, cfg.duty_bottom, cfg.duty_top);
            end else begin
              // step down, but not below zero
              duty_nxt = clamp_duty((duty_r == '0) ? 9'd0 : dec9,
                                    cfg.duty_bottom, cfg.duty_top);
              mode_nxt = ST_DEC;
            end
          end
          default: ;
        endcase
      end
      FUNC_DUTY_UP: begin
        if (duty_r < cfg.duty_top) duty_nxt = duty_r + 8'd1;
      end
      FUNC_DUTY_DOWN: begin
        if (duty_r > cfg.duty_bottom) duty_nxt = duty_r - 8'd1;
      end
      FUNC_PWM_OFF: pwm_nxt = 1'b0;
      FUNC_PWM_ON:  pwm_nxt = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    unique case (mode_nxt)
      ST_DEC:  mode_code = MODE_DEC;
      ST_INC:  mode_code = MODE_INC;
      default: mode_code = MODE_SHDN;
    endcase
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[OUT_DUTY_LSB +: DUTY_W]  = duty_nxt;
    out_data_nxt[OUT_PWM_BIT]             = pwm_nxt;
    out_data_nxt[OUT_MODE_LSB +: MODE_W]  = mode_code;
    out_data_nxt[OUT_PV_MV_LSB +: MV_W]   = q_item.pv_mv;
    out_data_nxt[OUT_PV_MA_LSB +: MA_W]   = q_item.pv_ma;
    out_data_nxt[OUT_BAT_MV_LSB +: MV_W]  = q_item.bat_mv;
    out_data_nxt[OUT_BAT_IN_LSB +: MA_W]  = q_item.bat_in_ma;
    out_data_nxt[OUT_BAT_OUT_LSB +: MA_W] = q_item.bat_out_ma;
    out_data_nxt[OUT_PV_OK_BIT]           = q_item.pv_ok;
    out_data_nxt[OUT_BAT_OK_BIT]          = q_item.bat_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ST_SHDN;
      duty_r      <= DUTY_RESET;
      pwm_r       <= 1'b0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        mode_r <= mode_nxt;
        duty_r <= duty_nxt;
        pwm_r  <= pwm_nxt;
        prev_r <= prev_nxt;
      end
      if (q_ready) out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data_r <= out_data_nxt;
  end

endmodule

// ===== hw/rtl/mppt_perturb_observe_controller.sv =====
// ----------------------------------------------------------------------------
// mppt_perturb_observe_controller
// Perturb-and-observe solar charge controller with a register write port.
// ----------------------------------------------------------------------------
// Every item on the input stream (a sample of five ADC readings or a manual
// command, selected by in_tuser) yields exactly one result on the output
// stream. The block takes one item per clock cycle unless back-pressure from
// the output has filled the queue; each item passes through the two-stage
// scaling multiplier (product, then divide by 1000 through a reciprocal
// multiply), the item queue and the output register. The queue lets the
// input keep flowing while the output is stalled, until the queue is full.
// Registers are written through the cfg port, which is always ready; write
// them only while no item is in flight.
module mppt_perturb_observe_controller
  import mppt_po_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF,
  parameter int Q_DEPTH  = Q_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // cfg write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pv_volt_raw[9:0], pv_curr_raw[19:10], bat_volt_raw[29:20],
  // bat_in_curr_raw[39:30], bat_out_curr_raw[49:40], zero[55:50]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func[2:0]
  input  logic [FUNC_W-1:0]      in_tuser,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // duty[7:0], pwm_on[8], mode[10:9], pv_mv[26:11], pv_ma[37:27],
  // bat_mv[53:38], bat_in_ma[64:54], bat_out_ma[75:65], pv_curr_valid[76],
  // bat_curr_valid[77], zero[79:78]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cfg_t  cfg_r;
  logic  q_push, q_push_ready, q_valid, q_ready;
  item_t q_push_item, q_pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_PV_START:   cfg_r.pv_start_mv    <= cfg_data;
        REG_BAT_FULL:   cfg_r.bat_full_mv    <= cfg_data;
        REG_MIN_CHARGE: cfg_r.min_charge_ma  <= cfg_data[CHG_W-1:0];
        REG_DUTY_TOP:   cfg_r.duty_top       <= cfg_data[DUTY_W-1:0];
        REG_DUTY_BOT:   cfg_r.duty_bottom    <= cfg_data[DUTY_W-1:0];
        REG_SENSE_OK:   cfg_r.sense_valid_mv <= cfg_data;
        REG_PV_SCALE:   cfg_r.pv_scale       <= cfg_data[SCALE_W-1:0];
        REG_BAT_SCALE:  cfg_r.bat_scale      <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  mppt_po_front #(
    .ADC_BITS(ADC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cfg      (cfg_r),
    .q_push   (q_push),
    .q_ready  (q_push_ready),
    .q_item   (q_push_item)
  );

  mppt_po_fifo #(
    .DEPTH(Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(q_push),
    .push_ready(q_push_ready),
    .push_item (q_push_item),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_item  (q_pop_item)
  );

  mppt_po_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_pop_item),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

// ===== hw/rtl/mppt_po_chk.sv =====
// ----------------------------------------------------------------------------
// mppt_po_chk
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module mppt_po_chk
  import mppt_po_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // a valid-current flag means the voltage beat a threshold, so it is nonzero
  a_flag_needs_volt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[OUT_PV_OK_BIT] || out_tdata[OUT_PV_MV_LSB +: MV_W] != '0)
                && (!out_tdata[OUT_BAT_OK_BIT] || out_tdata[OUT_BAT_MV_LSB +: MV_W] != '0))
    else $error("current-valid flag without voltage");

  // currents are doubled readings, never odd
  a_curr_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[OUT_PV_MA_LSB] && !out_tdata[OUT_BAT_IN_LSB]
                && !out_tdata[OUT_BAT_OUT_LSB])
    else $error("odd scaled current");

endmodule

bind mppt_perturb_observe_controller mppt_po_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
